[hdl/fpsa_pkg.sv]
// Package for the free page stack allocator: widths, item kind codes and the
// result beat type shared between the controller and the top level.
// Depends on nothing.
package fpsa_pkg;

   // Word and page geometry.
   localparam int unsigned DATA_W          = 64;
   localparam int unsigned PAGE_SHIFT      = 12;
   localparam int unsigned PAGE_NUM_W      = DATA_W - PAGE_SHIFT;
   localparam logic [DATA_W-1:0] PAGE_BYTES = DATA_W'(1) << PAGE_SHIFT;
   localparam logic [DATA_W-1:0] PAGE_MASK  = PAGE_BYTES - DATA_W'(1);

   // Default number of entries in the free stack.
   localparam int unsigned STACK_DEPTH_DEF = 1024;

   // Item kind codes.
   localparam logic [1:0] KIND_REGION = 2'd0;
   localparam logic [1:0] KIND_ALLOC  = 2'd1;
   localparam logic [1:0] KIND_FREE   = 2'd2;

   // One result beat handed from the controller to the output register.
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] page_address;
      logic              page_granted;
      logic              pushes_dropped;
      logic [DATA_W-1:0] usable_bytes;
      logic [DATA_W-1:0] highest_end;
   } result_type;

endpackage

[hdl/fpsa_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. Depends on nothing.
module fpsa_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/fpsa_ctrl.sv]
// Sequencer of the free page stack allocator: takes one item at a time, keeps
// the stack level and counters, and drives the stack memory ports.
// Depends on fpsa_pkg.
module fpsa_ctrl #(
   parameter int unsigned STACK_DEPTH = fpsa_pkg::STACK_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic [fpsa_pkg::DATA_W-1:0]         req_region_base,
   input  logic [fpsa_pkg::DATA_W-1:0]         req_region_length,
   input  logic                                req_region_usable,
   input  logic [fpsa_pkg::DATA_W-1:0]         req_freed_address,
   // Configuration.
   input  logic                                csr_wr_en,
   input  logic [fpsa_pkg::DATA_W-1:0]         csr_wr_data,
   // Result towards the output register.
   output fpsa_pkg::result_type                res,
   input  logic                                res_take,
   // Stack memory.
   output logic                                mem_wr_en,
   output logic [$clog2(STACK_DEPTH)-1:0]      mem_wr_addr,
   output logic [fpsa_pkg::DATA_W-1:0]         mem_wr_data,
   output logic                                mem_rd_en,
   output logic [$clog2(STACK_DEPTH)-1:0]      mem_rd_addr,
   input  logic [fpsa_pkg::DATA_W-1:0]         mem_rd_data,
   // Current stack level.
   output logic [$clog2(STACK_DEPTH+1)-1:0]    stack_level
);

   localparam int unsigned DW = fpsa_pkg::DATA_W;
   localparam int unsigned PW = fpsa_pkg::PAGE_NUM_W;
   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL_LEVEL = CW'(STACK_DEPTH);

   // Sequencer states.
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_EXEC     = 3'd1;
   localparam logic [2:0] S_RGN_SPAN = 3'd2;
   localparam logic [2:0] S_PUSH     = 3'd3;
   localparam logic [2:0] S_POP      = 3'd4;
   localparam logic [2:0] S_DONE     = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    kind_ff, kind_in;
   logic [DW-1:0] base_ff, base_in;
   logic [DW-1:0] len_ff, len_in;
   logic          usable_ff, usable_in;
   logic [DW-1:0] freed_ff, freed_in;
   logic [DW-1:0] offset_ff, offset_in;
   logic [CW-1:0] count_ff, count_in;
   logic [DW-1:0] usable_total_ff, usable_total_in;
   logic [DW-1:0] max_end_ff, max_end_in;
   logic [DW-1:0] end_ff, end_in;
   logic [DW-1:0] lo_ff, lo_in;
   logic [PW-1:0] pages_ff, pages_in;
   logic [DW-1:0] push_addr_ff, push_addr_in;
   logic [DW-1:0] page_addr_ff, page_addr_in;
   logic          granted_ff, granted_in;
   logic          dropped_ff, dropped_in;

   logic [DW-1:0] hi;
   logic [DW:0]   span;
   logic [CW-1:0] count_dec;

   assign hi        = end_ff & ~fpsa_pkg::PAGE_MASK;
   assign span      = {1'b0, hi} - {1'b0, lo_ff};
   assign count_dec = count_ff - CW'(1);

   // Next-state logic of the sequencer and its datapath.
   always_comb begin
      state_in        = state_ff;
      kind_in         = kind_ff;
      base_in         = base_ff;
      len_in          = len_ff;
      usable_in       = usable_ff;
      freed_in        = freed_ff;
      offset_in       = offset_ff;
      count_in        = count_ff;
      usable_total_in = usable_total_ff;
      max_end_in      = max_end_ff;
      end_in          = end_ff;
      lo_in           = lo_ff;
      pages_in        = pages_ff;
      push_addr_in    = push_addr_ff;
      page_addr_in    = page_addr_ff;
      granted_in      = granted_ff;
      dropped_in      = dropped_ff;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = count_ff[AW-1:0];
      mem_wr_data     = freed_ff;
      mem_rd_en       = 1'b0;
      mem_rd_addr     = count_dec[AW-1:0];

      if (csr_wr_en) begin
         offset_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               base_in   = req_region_base;
               len_in    = req_region_length;
               usable_in = req_region_usable;
               freed_in  = req_freed_address;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            page_addr_in = '0;
            granted_in   = 1'b0;
            dropped_in   = 1'b0;
            state_in     = S_DONE;
            case (kind_ff)
               fpsa_pkg::KIND_REGION: begin
                  // Region end and first aligned page; the usable total grows here for a usable region.
                  end_in = base_ff + len_ff;
                  lo_in  = (base_ff + fpsa_pkg::PAGE_MASK) & ~fpsa_pkg::PAGE_MASK;
                  if (usable_ff) begin
                     usable_total_in = usable_total_ff + len_ff;
                  end
                  state_in = S_RGN_SPAN;
               end
               fpsa_pkg::KIND_ALLOC: begin
                  // Pop: issue the read of the top entry.
                  if (count_ff != '0) begin
                     mem_rd_en = 1'b1;
                     count_in  = count_dec;
                     state_in  = S_POP;
                  end
               end
               fpsa_pkg::KIND_FREE: begin
                  // Push the returned page unless it is null or the stack is full.
                  if (freed_ff != '0) begin
                     if (count_ff == FULL_LEVEL) begin
                        dropped_in = 1'b1;
                     end else begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + CW'(1);
                     end
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_RGN_SPAN: begin
            // Raise the highest end and size the run of whole pages.
            if (end_ff > max_end_ff) begin
               max_end_in = end_ff;
            end
            if (usable_ff && !span[DW] && (span[DW-1:0] != '0)) begin
               pages_in = span[DW-1:fpsa_pkg::PAGE_SHIFT];
            end else begin
               pages_in = '0;
            end
            push_addr_in = lo_ff + offset_ff;
            state_in     = usable_ff ? S_PUSH : S_DONE;
         end
         S_PUSH: begin
            // One page a cycle in ascending order until done or full.
            if (pages_ff == '0) begin
               state_in = S_DONE;
            end else if (count_ff == FULL_LEVEL) begin
               dropped_in = 1'b1;
               state_in   = S_DONE;
            end else begin
               mem_wr_en    = 1'b1;
               mem_wr_data  = push_addr_ff;
               count_in     = count_ff + CW'(1);
               push_addr_in = push_addr_ff + fpsa_pkg::PAGE_BYTES;
               pages_in     = pages_ff - PW'(1);
            end
         end
         S_POP: begin
            page_addr_in = mem_rd_data;
            granted_in   = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and counters are cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         offset_ff       <= '0;
         count_ff        <= '0;
         usable_total_ff <= '0;
         max_end_ff      <= '0;
      end else begin
         state_ff        <= state_in;
         offset_ff       <= offset_in;
         count_ff        <= count_in;
         usable_total_ff <= usable_total_in;
         max_end_ff      <= max_end_in;
      end
   end

   // Item and working registers.
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      base_ff      <= base_in;
      len_ff       <= len_in;
      usable_ff    <= usable_in;
      freed_ff     <= freed_in;
      end_ff       <= end_in;
      lo_ff        <= lo_in;
      pages_ff     <= pages_in;
      push_addr_ff <= push_addr_in;
      page_addr_ff <= page_addr_in;
      granted_ff   <= granted_in;
      dropped_ff   <= dropped_in;
   end

   assign req_stall = (state_ff != S_IDLE);

   assign res.valid          = (state_ff == S_DONE);
   assign res.page_address   = page_addr_ff;
   assign res.page_granted   = granted_ff;
   assign res.pushes_dropped = dropped_ff;
   assign res.usable_bytes   = usable_total_ff;
   assign res.highest_end    = max_end_ff;

   assign stack_level = count_ff;

endmodule

[hdl/free_page_stack_allocator_top.sv]
// Top level of the free page stack allocator: sequencer, stack memory and
// the output register. Depends on fpsa_pkg, fpsa_ctrl and fpsa_ram.
//
// Usage:
//   Items enter on the req_ channel (valid/stall). Kind 0 adds a memory
//   region, kind 1 allocates a page, kind 2 frees a page. Each item gives
//   exactly one beat on the rsp_ channel carrying the popped address, the
//   grant and drop flags and the running usable byte and highest end totals.
//   The direct-map offset is written through csr_wr_en/csr_wr_data while the
//   block is idle; it is added to every page address of a region.
//   Items are processed one at a time. A free, an unused kind or an
//   allocate on an empty stack passes through the execute and done states
//   of the sequencer, an allocate that pops also through the pop state (for
//   the registered read of the stack memory), a region through the span
//   state and, if usable, the push state for each page pushed, since the single write
//   port of the stack memory takes one page a cycle. The result beat is loaded
//   into the output register from the done state once that register is free.
//   Reset (synchronous, active high) empties the stack, clears the counters
//   and the offset; the stack memory itself needs no clearing pass.
//   While rsp_stall is high the output register holds its beat; the next
//   item is still accepted and worked on, and its result waits in the
//   sequencer until the output register frees up.
module free_page_stack_allocator_top #(
   parameter int unsigned STACK_DEPTH = fpsa_pkg::STACK_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // Input channel.
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_kind,
   input  logic [fpsa_pkg::DATA_W-1:0] req_region_base,
   input  logic [fpsa_pkg::DATA_W-1:0] req_region_length,
   input  logic                        req_region_usable,
   input  logic [fpsa_pkg::DATA_W-1:0] req_freed_address,
   // Result channel.
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [fpsa_pkg::DATA_W-1:0] rsp_page_address,
   output logic                        rsp_page_granted,
   output logic                        rsp_pushes_dropped,
   output logic [fpsa_pkg::DATA_W-1:0] rsp_usable_bytes,
   output logic [fpsa_pkg::DATA_W-1:0] rsp_highest_end,
   // Configuration.
   input  logic                        csr_wr_en,
   input  logic [fpsa_pkg::DATA_W-1:0] csr_wr_data
);

   localparam int unsigned DW = fpsa_pkg::DATA_W;
   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

   fpsa_pkg::result_type res;
   logic                 res_take;
   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [DW-1:0]        mem_wr_data;
   logic                 mem_rd_en;
   logic [AW-1:0]        mem_rd_addr;
   logic [DW-1:0]        mem_rd_data;
   logic [CW-1:0]        stack_level;

   logic                 rsp_valid_ff, rsp_valid_in;
   fpsa_pkg::result_type rsp_beat_ff;

   fpsa_ctrl #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_region_base   (req_region_base),
      .req_region_length (req_region_length),
      .req_region_usable (req_region_usable),
      .req_freed_address (req_freed_address),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .res               (res),
      .res_take          (res_take),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_en         (mem_rd_en),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data),
      .stack_level       (stack_level)
   );

   fpsa_ram #(
      .WIDTH (DW),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Output register: loads when empty or when its beat is being taken.
   assign res_take = res.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_beat_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_page_address   = rsp_beat_ff.page_address;
   assign rsp_page_granted   = rsp_beat_ff.page_granted;
   assign rsp_pushes_dropped = rsp_beat_ff.pushes_dropped;
   assign rsp_usable_bytes   = rsp_beat_ff.usable_bytes;
   assign rsp_highest_end    = rsp_beat_ff.highest_end;

   // The stack level never goes beyond the depth of the memory.
   assert property (@(posedge clock) disable iff (reset)
      stack_level <= CW'(STACK_DEPTH))
      else $error("stack level beyond depth");

   // An accepted item holds the input channel off in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not held off after an accepted beat");

   // A new result beat only comes from an item that was in flight.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result beat without an item in flight");

   // A granted beat is never taken in the cycle right after a push to the stack.
   assert property (@(posedge clock) disable iff (reset)
      (res_take && res.page_granted) |-> !$past(mem_wr_en, 1))
      else $error("grant issued right after a push");

endmodule
